/* rtl/rmslm_pkg.sv */
package rmslm_pkg;

  // Percent scale in unsigned Q7.8.
  localparam logic [14:0] FULL_Q8 = 15'd25600;
  localparam logic [14:0] HALF_Q8 = 15'd12800;
  // Bias that rounds the merge product to the nearest multiple of 12800.
  localparam logic [12:0] MERGE_BIAS = 13'd6400;
  // 19.2 * log10(2) in Q.16.
  localparam logic [18:0] LOG_TO_PCT_Q16 = 19'd378783;
  // Rounding bias for the Q.16 * Q.16 -> Q7.8 step (half of 2^24).
  localparam logic [23:0] PCT_ROUND = 24'h800000;
  // ceil(2^24 / 25), used to divide by 25 after a shift by 9.
  localparam logic [19:0] RECIP_25 = 20'd671089;
  localparam logic [4:0]  DIV_25 = 5'd25;
  // Fraction bits of the log2 result.
  localparam int unsigned LOG_FRAC_BITS = 16;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ACC_RD,
    S_ACC_WR,
    S_FIN_START,
    S_LOG_NORM,
    S_LOG_MUL,
    S_LOG_STEP,
    S_LOG_DONE,
    S_RD_SUM,
    S_CHK_SUM,
    S_PCT,
    S_PCT_ROUND,
    S_FOLD,
    S_MERGE_RECIP,
    S_MERGE_CORR,
    S_MERGE_FOLD,
    S_NEXT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic acc_write;
    logic rd_chan;
    logic chan_clr;
    logic chan_next;
    logic log_load_frames;
    logic log_load_sum;
    logic log_shift;
    logic log_mload;
    logic log_mul;
    logic log_step;
    logic save_lfr;
    logic pct_zero;
    logic pct_eval;
    logic pct_round;
    logic level_take;
    logic merge_mul;
    logic merge_recip;
    logic merge_corr;
    logic merge_fold;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic fin_ok;
    logic norm_top;
    logic iter_done;
    logic sum_zero;
    logic pct_full;
    logic chan_first;
    logic chan_last;
    logic out_free;
  } status_t;

endpackage

/* rtl/rmslm_ctrl.sv */
module rmslm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  rmslm_pkg::status_t st,
  output rmslm_pkg::cmd_t    cmd
);
  import rmslm_pkg::*;

  state_t state, state_next;
  // Set while the log unit works on a channel sum rather than the frame count.
  logic log_sum, log_sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      log_sum <= 1'b0;
    end else begin
      state   <= state_next;
      log_sum <= log_sum_next;
    end
  end

  always_comb begin
    state_next   = state;
    log_sum_next = log_sum;
    cmd          = '0;
    in_stall     = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_ACC_RD;
        end
      end
      S_ACC_RD: state_next = S_ACC_WR;
      S_ACC_WR: begin
        cmd.acc_write = 1'b1;
        state_next    = st.last ? S_FIN_START : S_IDLE;
      end
      S_FIN_START: begin
        if (st.fin_ok) begin
          cmd.log_load_frames = 1'b1;
          cmd.chan_clr        = 1'b1;
          log_sum_next        = 1'b0;
          state_next          = S_LOG_NORM;
        end else begin
          state_next = S_DONE;
        end
      end
      S_LOG_NORM: begin
        if (st.norm_top) begin
          cmd.log_mload = 1'b1;
          state_next    = S_LOG_MUL;
        end else begin
          cmd.log_shift = 1'b1;
        end
      end
      S_LOG_MUL: begin
        cmd.log_mul = 1'b1;
        state_next  = S_LOG_STEP;
      end
      S_LOG_STEP: begin
        cmd.log_step = 1'b1;
        state_next   = st.iter_done ? S_LOG_DONE : S_LOG_MUL;
      end
      S_LOG_DONE: begin
        if (log_sum) begin
          state_next = S_PCT;
        end else begin
          cmd.save_lfr = 1'b1;
          state_next   = S_RD_SUM;
        end
      end
      S_RD_SUM: begin
        cmd.rd_chan = 1'b1;
        state_next  = S_CHK_SUM;
      end
      S_CHK_SUM: begin
        if (st.sum_zero) begin
          cmd.pct_zero = 1'b1;
          state_next   = S_FOLD;
        end else begin
          cmd.log_load_sum = 1'b1;
          log_sum_next     = 1'b1;
          state_next       = S_LOG_NORM;
        end
      end
      S_PCT: begin
        cmd.pct_eval = 1'b1;
        state_next   = st.pct_full ? S_FOLD : S_PCT_ROUND;
      end
      S_PCT_ROUND: begin
        cmd.pct_round = 1'b1;
        state_next    = S_FOLD;
      end
      S_FOLD: begin
        if (st.chan_first) begin
          cmd.level_take = 1'b1;
          state_next     = S_NEXT;
        end else begin
          cmd.merge_mul = 1'b1;
          state_next    = S_MERGE_RECIP;
        end
      end
      S_MERGE_RECIP: begin
        cmd.merge_recip = 1'b1;
        state_next      = S_MERGE_CORR;
      end
      S_MERGE_CORR: begin
        cmd.merge_corr = 1'b1;
        state_next     = S_MERGE_FOLD;
      end
      S_MERGE_FOLD: begin
        cmd.merge_fold = 1'b1;
        state_next     = S_NEXT;
      end
      S_NEXT: begin
        if (st.chan_last) begin
          state_next = S_DONE;
        end else begin
          cmd.chan_next = 1'b1;
          state_next    = S_RD_SUM;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* rtl/rmslm_dp.sv */
module rmslm_dp #(
  parameter int MAX_CHANNELS = 32,
  parameter int SAMPLE_BITS  = 16,
  parameter int MAX_FRAMES   = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [5:0]                    cfg_data,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [14:0]                   level,
  output logic                          overflow,
  input  rmslm_pkg::cmd_t               cmd,
  output rmslm_pkg::status_t            st
);
  import rmslm_pkg::*;

  localparam int CI_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int FC_W  = $clog2(MAX_FRAMES + 1);
  localparam int SUM_W = 2 * SAMPLE_BITS - 1 + $clog2(MAX_FRAMES);
  localparam int LW    = (SUM_W > 32) ? SUM_W : 32;
  localparam int E_W   = $clog2(LW);
  localparam int LQ_W  = E_W + 16;
  localparam int L_W   = LQ_W + 2;
  localparam int KD_W  = 19 + L_W;
  localparam logic signed [L_W-1:0] L_OFF = L_W'(2 * (SAMPLE_BITS - 1)) << 16;

  // Configuration and block bookkeeping.
  logic [5:0]       chan_count;
  logic [CI_W-1:0]  channel_index;
  logic [FC_W-1:0]  frame_count;
  logic             overflow_seen;

  // Captured request.
  logic [SAMPLE_BITS-1:0]   mag;
  logic                     acc_last;
  logic                     acc_keep;
  logic [CI_W-1:0]          acc_idx;
  logic [2*SAMPLE_BITS-1:0] sq;

  // Accumulator memory with per-entry valid bits.
  logic [SUM_W-1:0]        sums [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0] vld;
  logic [SUM_W-1:0]        rd_data;
  logic                    rd_vld;
  logic [CI_W-1:0]         rd_addr;
  logic [SUM_W-1:0]        eff_sum;

  // Log unit.
  logic [LW-1:0]   lg_norm;
  logic [E_W-1:0]  lg_e;
  logic [31:0]     lg_m;
  logic [63:0]     lg_prod;
  logic [15:0]     lg_frac;
  logic [3:0]      lg_iter;
  logic [LQ_W-1:0] lfr;
  logic [32:0]     lg_t;

  // Channel loop and level arithmetic.
  logic [CI_W-1:0]        chan;
  logic signed [L_W-1:0]  lval;
  logic [L_W-1:0]         dval;
  logic [KD_W-1:0]        kd;
  logic [KD_W:0]          kd_rnd;
  logic [KD_W-24:0]       dec;
  logic [14:0]            pct;
  logic [14:0]            acc_level;
  logic [29:0]            ab;
  logic [30:0]            ab_rnd;
  logic [21:0]            mx;
  logic [41:0]            mxr;
  logic [17:0]            qe;
  logic [22:0]            qe25;
  logic [16:0]            mq;
  logic signed [19:0]     z;

  logic            cc_ok;
  logic [CI_W-1:0] idx;
  logic [6:0]      idx_inc;
  logic            keep;
  logic            ovf_set;
  logic            frame_inc;

  assign cc_ok = (chan_count != 6'd0) && ({1'b0, chan_count} <= 7'(MAX_CHANNELS));
  assign idx   = (7'(channel_index) < {1'b0, chan_count}) ? channel_index : '0;
  assign idx_inc = 7'(idx) + 7'd1;

  always_comb begin
    keep      = 1'b1;
    ovf_set   = 1'b0;
    frame_inc = 1'b0;
    if (overflow_seen) begin
      keep = 1'b0;
    end else if (idx == '0) begin
      if (frame_count >= FC_W'(MAX_FRAMES)) begin
        keep    = 1'b0;
        ovf_set = 1'b1;
      end else begin
        frame_inc = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chan_count    <= 6'd1;
      channel_index <= '0;
      frame_count   <= '0;
      overflow_seen <= 1'b0;
      acc_keep      <= 1'b0;
      acc_last      <= 1'b0;
      vld           <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        chan_count <= cfg_data;
      end
      if (cmd.accept) begin
        acc_last <= last;
        acc_keep <= cc_ok && keep;
        if (cc_ok) begin
          if (ovf_set) overflow_seen <= 1'b1;
          if (frame_inc) frame_count <= frame_count + 1'b1;
          if (keep) begin
            channel_index <= (idx_inc >= {1'b0, chan_count}) ? '0 : idx_inc[CI_W-1:0];
          end
        end
      end
      if (cmd.acc_write && acc_keep) begin
        vld[acc_idx] <= 1'b1;
      end
      if (cmd.finish) begin
        out_valid     <= 1'b1;
        vld           <= '0;
        channel_index <= '0;
        frame_count   <= '0;
        overflow_seen <= 1'b0;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request capture and squaring.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      acc_idx <= idx;
      mag     <= sample[SAMPLE_BITS-1] ? (~$unsigned(sample) + 1'b1) : $unsigned(sample);
    end
    sq <= mag * mag;
  end

  // Accumulator memory: registered read, single write port.
  assign rd_addr = cmd.rd_chan ? chan : acc_idx;
  assign eff_sum = rd_vld ? rd_data : '0;

  always_ff @(posedge clk) begin
    rd_data <= sums[rd_addr];
    rd_vld  <= vld[rd_addr];
    if (cmd.acc_write && acc_keep) begin
      sums[acc_idx] <= eff_sum + SUM_W'(sq);
    end
  end

  // Log2 unit: normalize one bit per cycle, then square the mantissa once per fraction bit.
  assign lg_t = lg_prod[63:31];

  always_ff @(posedge clk) begin
    if (cmd.log_load_frames || cmd.log_load_sum) begin
      lg_norm <= cmd.log_load_sum ? LW'(eff_sum) : LW'(frame_count);
      lg_e    <= E_W'(LW - 1);
      lg_frac <= '0;
      lg_iter <= '0;
    end
    if (cmd.log_shift) begin
      lg_norm <= lg_norm << 1;
      lg_e    <= lg_e - 1'b1;
    end
    if (cmd.log_mload) lg_m <= lg_norm[LW-1 -: 32];
    if (cmd.log_mul) lg_prod <= lg_m * lg_m;
    if (cmd.log_step) begin
      lg_iter <= lg_iter + 1'b1;
      if (lg_t[32]) begin
        lg_m    <= lg_t[32:1];
        lg_frac <= {lg_frac[14:0], 1'b1};
      end else begin
        lg_m    <= lg_t[31:0];
        lg_frac <= {lg_frac[14:0], 1'b0};
      end
    end
    if (cmd.save_lfr) lfr <= {lg_e, lg_frac};
  end

  // Channel percentage and merge.
  assign lval   = $signed({2'b00, lg_e, lg_frac}) - $signed({2'b00, lfr}) - L_OFF;
  assign dval   = $unsigned(-lval);
  assign kd_rnd = {1'b0, kd} + (KD_W+1)'(PCT_ROUND);
  assign dec    = kd_rnd[KD_W:24];
  assign ab_rnd = {1'b0, ab} + 31'(MERGE_BIAS);
  assign qe     = mxr[41:24];
  assign qe25   = qe * DIV_25;

  always_comb begin
    if ((acc_level < HALF_Q8) && (pct < HALF_Q8)) begin
      z = $signed({3'b000, mq});
    end else begin
      z = $signed({4'b0000, acc_level, 1'b0}) + $signed({4'b0000, pct, 1'b0})
        - $signed({5'b00000, FULL_Q8}) - $signed({3'b000, mq});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.chan_clr) chan <= '0;
    if (cmd.chan_next) chan <= chan + 1'b1;
    if (cmd.pct_zero) pct <= '0;
    if (cmd.pct_eval) begin
      kd <= LOG_TO_PCT_Q16 * dval;
      if (!lval[L_W-1]) pct <= FULL_Q8;
    end
    if (cmd.pct_round) begin
      pct <= (dec >= (KD_W-23)'(FULL_Q8)) ? 15'd0 : FULL_Q8 - dec[14:0];
    end
    if (cmd.level_take) acc_level <= pct;
    if (cmd.merge_mul) ab <= acc_level * pct;
    if (cmd.merge_recip) begin
      mx  <= ab_rnd[30:9];
      mxr <= ab_rnd[30:9] * RECIP_25;
    end
    if (cmd.merge_corr) begin
      mq <= (qe25 > 23'(mx)) ? 17'(qe - 1'b1) : qe[16:0];
    end
    if (cmd.merge_fold) begin
      if (z < 0) acc_level <= '0;
      else if (z > $signed({5'b00000, FULL_Q8})) acc_level <= FULL_Q8;
      else acc_level <= z[14:0];
    end
    if (cmd.finish) begin
      level    <= st.fin_ok ? acc_level : 15'd0;
      overflow <= overflow_seen;
    end
  end

  assign st.last       = acc_last;
  assign st.fin_ok     = cc_ok && (frame_count != '0);
  assign st.norm_top   = lg_norm[LW-1];
  assign st.iter_done  = (lg_iter == 4'd15);
  assign st.sum_zero   = (eff_sum == '0);
  assign st.pct_full   = !lval[L_W-1];
  assign st.chan_first = (chan == '0);
  assign st.chan_last  = ((7'(chan) + 7'd1) >= {1'b0, chan_count});
  assign st.out_free   = !out_valid || !out_stall;

`ifndef SYNTHESIS
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || !out_stall))
    else $error("result loaded while the output register was still held");
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (level <= FULL_Q8))
    else $error("level above full scale");
  a_frame_limit: assert property (@(posedge clk) disable iff (rst)
    frame_count <= FC_W'(MAX_FRAMES))
    else $error("frame count passed the limit");
  a_write_after_read: assert property (@(posedge clk) disable iff (rst)
    cmd.acc_write |-> $past(cmd.accept, 2))
    else $error("accumulator write without a captured request");
`endif

endmodule

/* rtl/multichannel_rms_level_meter.sv */
// Multichannel RMS level meter. Interleaved signed samples, channel 0 first, are
// squared and summed per channel; the request flagged last closes the block and
// produces one merged level in unsigned Q7.8 percent (0 to 25600) together with a
// flag that tells whether frames past MAX_FRAMES were dropped. A channel count of
// zero or above MAX_CHANNELS gives a level of zero. Each sample request passes
// through capture, accumulator read and accumulator write, a read-modify-write
// of the accumulator memory, and the next request is taken only after the write.
// A block end adds the per-channel evaluation: the log2 of the frame count, then
// per channel its log2 (a one-bit-per-cycle normalize over LW bits, LW being the
// accumulator width but at least 32, plus sixteen squaring steps) and the read,
// the percentage and the merge.
// The result sits in an output register, so the next block can start while it
// waits to be taken; it is held until then.
module multichannel_rms_level_meter #(
  parameter int MAX_CHANNELS = 32,
  parameter int SAMPLE_BITS  = 16,
  parameter int MAX_FRAMES   = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [5:0]                    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [14:0]                   level,
  output logic                          overflow
);
  import rmslm_pkg::*;

  // Commands from the sequencer and status from the datapath.
  cmd_t    cmd;
  status_t st;

  rmslm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // The datapath holds the configuration, the accumulators, the log unit and the
  // output register.
  rmslm_dp #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS),
    .MAX_FRAMES   (MAX_FRAMES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .sample    (sample),
    .last      (last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .level     (level),
    .overflow  (overflow),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

/* dv/multichannel_rms_level_meter_test.sv */
module multichannel_rms_level_meter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rmslm_pkg::*;

  // Block sizes of the design under test.
  localparam int CHANNELS = 32;
  localparam int FRAMES_MAX = 4096;
  // A run of this many cycles means the block has stopped making progress.
  localparam int CYCLE_LIMIT = 3000000;
  // Cycles a sample request may still be in flight after it was accepted.
  localparam int SAMPLE_SETTLE = 12;
  // Drain time at the end, enough for a full 32 channel evaluation.
  localparam int END_DRAIN = 4000;

  typedef struct {
    logic [14:0] level;
    logic        overflow;
  } meter_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [5:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic signed [15:0] sample = '0;
  logic        last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [14:0] level;
  logic        overflow;

  // The testbench keeps its own copy of the meter state, updated on every
  // accepted sample request, and queues the level expected at each block end.
  logic [42:0] power_sums[CHANNELS];
  int unsigned frame_pos;
  int unsigned frames_seen;
  bit          frames_dropped;
  int unsigned active_channels;
  meter_result_t expected_levels[$];

  int mismatches = 0;
  int cycles = 0;
  // When set, neither side inserts idle cycles, so back-to-back traffic is seen.
  bit no_idle = 1'b0;

  multichannel_rms_level_meter dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample    (sample),
    .last      (last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .level     (level),
    .overflow  (overflow)
  );

  always #1 clk = ~clk;

  // The cycle counter doubles as the watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Idle lengths: mostly none or a few cycles, now and then a long pause.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // log2 of a positive integer in Q.16, with the fraction found by repeated
  // squaring of the mantissa held in Q1.31.
  function automatic longint log2_q16(longint unsigned x);
    int e;
    longint unsigned m;
    longint unsigned frac;
    e = 63;
    frac = 0;
    while (e > 0 && x[e] == 1'b0) e--;
    if (e >= 31) m = x >> (e - 31);
    else m = x << (31 - e);
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    return longint'(e) * 65536 + longint'(frac);
  endfunction

  // Percentage of one channel in Q7.8, from its power sum and the frame count.
  function automatic longint channel_percent(longint unsigned sum, int unsigned frames);
    longint l;
    longint unsigned d;
    longint unsigned dec;
    if (sum == 0) return 0;
    l = log2_q16(sum) - log2_q16(frames) - 30 * 65536;
    if (l >= 0) return 25600;
    d = longint'(-l);
    dec = (64'd378783 * d + (64'd1 << 23)) >> 24;
    if (dec >= 25600) return 0;
    return 25600 - longint'(dec);
  endfunction

  // Merge rule of two channel percentages, both in Q7.8.
  function automatic longint merge_percent(longint a, longint b);
    longint q;
    longint z;
    q = (a * b + 6400) / 12800;
    if (a < 12800 && b < 12800) z = q;
    else z = 2 * (a + b) - 25600 - q;
    if (z < 0) z = 0;
    if (z > 25600) z = 25600;
    return z;
  endfunction

  function automatic void clear_block();
    foreach (power_sums[i]) power_sums[i] = '0;
    frame_pos = 0;
    frames_seen = 0;
    frames_dropped = 1'b0;
  endfunction

  // Updates the state copy with one accepted sample request and, at a block
  // end, queues the merged level the block must report.
  function automatic void absorb_sample(logic signed [15:0] s, logic is_last);
    logic [15:0] mag;
    bit usable;
    bit keep;
    int unsigned idx;
    longint lvl;
    meter_result_t r;
    mag = s[15] ? (~s + 16'd1) : s;
    usable = active_channels != 0 && active_channels <= CHANNELS;
    lvl = 0;
    if (usable) begin
      idx = (frame_pos < active_channels) ? frame_pos : 0;
      keep = 1'b1;
      if (frames_dropped) begin
        keep = 1'b0;
      end else if (idx == 0) begin
        if (frames_seen >= FRAMES_MAX) begin
          keep = 1'b0;
          frames_dropped = 1'b1;
        end else begin
          frames_seen++;
        end
      end
      if (keep) begin
        power_sums[idx] = power_sums[idx] + 43'(mag) * 43'(mag);
        frame_pos = (idx + 1 >= active_channels) ? 0 : idx + 1;
      end
    end
    if (!is_last) return;
    if (usable && frames_seen != 0) begin
      lvl = channel_percent(power_sums[0], frames_seen);
      for (int c = 1; c < active_channels; c++)
        lvl = merge_percent(lvl, channel_percent(power_sums[c], frames_seen));
    end
    r.level = 15'(lvl);
    r.overflow = frames_dropped;
    expected_levels.push_back(r);
    clear_block();
  endfunction

  // Sends one sample request. Called and returning at a falling edge, so that
  // back-to-back requests keep in_valid high without a glitch.
  task automatic send_sample(logic signed [15:0] s, logic is_last);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    sample = s;
    last = is_last;
    do @(posedge clk); while (in_stall);
    absorb_sample(s, is_last);
    @(negedge clk);
  endtask

  task automatic stop_sending();
    in_valid = 1'b0;
    last = 1'b0;
  endtask

  // The register is written only with nothing in flight: every expected level
  // has arrived, and any sample request of an open block has settled.
  task automatic write_channel_count(logic [5:0] v);
    stop_sending();
    while (expected_levels.size() != 0) @(negedge clk);
    repeat (SAMPLE_SETTLE) @(negedge clk);
    cfg_write = 1'b1;
    cfg_data = v;
    @(negedge clk);
    active_channels = v;
    cfg_write = 1'b0;
    cfg_data = 6'($urandom);
  endtask

  // Random amplitude: a random word shifted down by a random amount spreads
  // the levels over the whole dB range.
  function automatic logic signed [15:0] random_sample();
    logic signed [15:0] v;
    v = 16'($urandom);
    return v >>> $urandom_range(0, 15);
  endfunction

  // Receiver side: random stall, with the checker on the accepting edge.
  always @(negedge clk) begin : stall_driver
    static int hold = 0;
    if (hold > 0) begin
      hold--;
    end else if (no_idle || rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 3) == 0);
      hold = pick_gap();
    end
  end

  always @(posedge clk) begin
    meter_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_levels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected level %0d overflow %0d", level, overflow);
      end else begin
        want = expected_levels.pop_front();
        if (level !== want.level || overflow !== want.overflow) begin
          mismatches++;
          if (mismatches <= 10)
            $display("level mismatch: expected %0d/%0d, got %0d/%0d",
                     want.level, want.overflow, level, overflow);
        end
      end
    end
  end

  // Reset value of the channel count is one; full scale, silence and the
  // most positive and the smallest positive sample are checked as single-sample blocks.
  task automatic test_reset_default();
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh0000, 1'b1);
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sh0001, 1'b1);
    stop_sending();
  endtask

  // Two channels: one loud and one silent, then a block whose final frame
  // lacks the second channel.
  task automatic test_missing_and_silent();
    write_channel_count(6'd2);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh0000, 1'b1);
    send_sample(16'sh4000, 1'b0);
    send_sample(-16'sh4000, 1'b0);
    send_sample(16'sh8000, 1'b1);
    stop_sending();
  endtask

  // Channel counts of zero and above the channel limit give a level of zero.
  task automatic test_bad_count();
    write_channel_count(6'd0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b1);
    write_channel_count(6'd33);
    send_sample(16'sh1234, 1'b1);
    write_channel_count(6'd63);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh0fff, 1'b1);
    stop_sending();
  endtask

  // Shrinking the channel count inside a block wraps the frame position back
  // to channel zero, which starts a new frame.
  task automatic test_count_change();
    write_channel_count(6'd3);
    send_sample(16'sh2000, 1'b0);
    send_sample(16'sh7000, 1'b0);
    send_sample(16'sh0100, 1'b0);
    send_sample(16'sh3000, 1'b0);
    send_sample(16'sh5000, 1'b0);
    write_channel_count(6'd2);
    send_sample(16'sh6000, 1'b0);
    send_sample(-16'sh0800, 1'b1);
    stop_sending();
  endtask

  // All 32 channels at full scale, one frame.
  task automatic test_all_channels();
    write_channel_count(6'd32);
    for (int c = 0; c < CHANNELS; c++)
      send_sample((c % 2 == 0) ? 16'sh8000 : 16'sh7fff, c == CHANNELS - 1);
    stop_sending();
  endtask

  // Mostly well-formed blocks of a few whole frames, some ending in a partial
  // frame, and a share of noise: random lengths with no frame structure.
  task automatic test_random_blocks();
    int sent;
    int frames;
    int len;
    int count_pick;
    logic [5:0] cc;
    bit silent;
    sent = 0;
    while (sent < 1500) begin
      count_pick = $urandom_range(0, 9);
      case (count_pick)
        0: cc = 6'd1;
        1: cc = 6'd32;
        2: cc = 6'd0;
        3: cc = 6'($urandom_range(33, 63));
        4: cc = 6'd2;
        default: cc = 6'($urandom_range(1, 8));
      endcase
      write_channel_count(cc);
      no_idle = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 9) == 0 || cc == 0 || cc > CHANNELS) begin
          len = $urandom_range(1, 12);
          for (int i = 0; i < len; i++) begin
            send_sample(random_sample(), i == len - 1);
            sent++;
          end
        end else begin
          frames = (cc > 8) ? $urandom_range(1, 2) : $urandom_range(1, 6);
          len = frames * cc - (($urandom_range(0, 3) == 0) ? $urandom_range(0, cc - 1) : 0);
          silent = ($urandom_range(0, 5) == 0);
          for (int i = 0; i < len; i++) begin
            send_sample(silent && (i % cc == 0) ? 16'sh0000 : random_sample(), i == len - 1);
            sent++;
          end
        end
      end
      stop_sending();
      no_idle = 1'b0;
    end
  endtask

  initial begin
    active_channels = 1;
    clear_block();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_default();
    test_missing_and_silent();
    test_bad_count();
    test_count_change();
    test_all_channels();
    test_random_blocks();

    stop_sending();
    while (expected_levels.size() != 0) @(negedge clk);
    repeat (END_DRAIN) @(negedge clk);
    if (mismatches == 0 && expected_levels.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
